[design/cigar_reference_position_expander_unit_assert.svh]
// Assertion macros for the CIGAR position expander RTL.
// Depends on nothing; included by the top-level expander module.
`ifndef CIGAR_REFERENCE_POSITION_EXPANDER_UNIT_ASSERT_SVH
`define CIGAR_REFERENCE_POSITION_EXPANDER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CRPE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("crpe check failed");

// Check that a condition never holds outside reset.
`define CRPE_NEVER(label, clk, rst_n, cond) \
	`CRPE_ASSERT(label, clk, rst_n, !(cond))

`endif

[design/crpe_pkg.sv]
// Shared types and constants for the CIGAR reference position expander.
// No dependencies; imported by the controller, the datapath and the top level.
package crpe_pkg;

	localparam int OUT_LANES        = 4;
	localparam int MAX_READ_LEN_DEF = 256;

	localparam int POS_W   = 32;
	localparam int START_W = 31;
	localparam int LEN_W   = 28;
	localparam int OP_W    = 4;
	localparam int CNT_W   = 3;

	localparam logic [OP_W-1:0] OP_M  = 4'd0;
	localparam logic [OP_W-1:0] OP_I  = 4'd1;
	localparam logic [OP_W-1:0] OP_D  = 4'd2;
	localparam logic [OP_W-1:0] OP_N  = 4'd3;
	localparam logic [OP_W-1:0] OP_S  = 4'd4;
	localparam logic [OP_W-1:0] OP_H  = 4'd5;
	localparam logic [OP_W-1:0] OP_EQ = 4'd7;
	localparam logic [OP_W-1:0] OP_X  = 4'd8;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // take the input word
		logic emit;   // write one result into the output register
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic run_start;   // the offered word produces at least one result
		logic group_last;  // the next result ends the current operation
		logic out_free;    // output register can take a result this cycle
	} dp_sts_t;

endpackage

[design/crpe_ctrl.sv]
// Controller for the CIGAR position expander: idle/run sequencing.
// Depends on crpe_pkg for the command and status structs.
module crpe_ctrl
	import crpe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.emit = (state_q == ST_RUN) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && sts.run_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.emit && sts.group_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/crpe_datapath.sv]
// Datapath for the CIGAR position expander: running position, run counter,
// lane builder and output register. Depends on crpe_pkg.
module crpe_datapath
	import crpe_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic                  in_first_word,
	input  logic [START_W-1:0]    in_start_pos,
	input  logic [OP_W-1:0]       in_op_code,
	input  logic [LEN_W-1:0]      in_op_length,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      out_pos [OUT_LANES],
	output logic [OUT_LANES-1:0]  out_noref,
	output logic [CNT_W-1:0]      out_lane_count,
	output logic                  out_run_last,
	output logic                  out_error
);

	localparam int RW = $clog2(MAX_READ_LEN + 1);

	logic [POS_W-1:0]     pos_q;
	logic [RW-1:0]        rem_q;
	logic                 has_ref_q;
	logic                 err_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     out_pos_q [OUT_LANES];
	logic [OUT_LANES-1:0] out_noref_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic                 out_last_q;
	logic                 out_err_q;

	logic [POS_W-1:0]     pos_base;
	logic                 is_ref_op;
	logic                 is_clip_ins;
	logic                 is_skip;
	logic                 is_nop;
	logic                 too_long;
	logic                 dec_err;
	logic [CNT_W-1:0]     grp_cnt;
	logic [POS_W-1:0]     lane_pos [OUT_LANES];
	logic [OUT_LANES-1:0] lane_noref;

	// Decode the offered word.
	always_comb begin
		is_ref_op   = 1'b0;
		is_clip_ins = 1'b0;
		is_skip     = 1'b0;
		is_nop      = 1'b0;
		unique case (in_op_code)
			OP_M, OP_EQ, OP_X: is_ref_op   = 1'b1;
			OP_I, OP_S:        is_clip_ins = 1'b1;
			OP_D, OP_N:        is_skip     = 1'b1;
			OP_H:              is_nop      = 1'b1;
			default:           is_nop      = 1'b0;
		endcase
	end

	assign too_long = (in_op_length > LEN_W'(MAX_READ_LEN));
	assign dec_err  = !(is_ref_op || is_clip_ins || is_skip || is_nop) ||
		((is_ref_op || is_clip_ins) && too_long);
	assign pos_base = in_first_word ? {1'b0, in_start_pos} : pos_q;

	assign sts.run_start  = dec_err ||
		((is_ref_op || is_clip_ins) && (in_op_length != '0));
	assign sts.group_last = err_q || (rem_q <= RW'(OUT_LANES));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Build one group of lanes from the remaining run.
	assign grp_cnt = (rem_q < RW'(OUT_LANES)) ? CNT_W'(rem_q) : CNT_W'(OUT_LANES);

	always_comb begin
		for (int k = 0; k < OUT_LANES; k++) begin
			lane_pos[k]   = '0;
			lane_noref[k] = 1'b0;
			if (!err_q && (CNT_W'(k) < grp_cnt)) begin
				if (has_ref_q) begin
					lane_pos[k] = pos_q + POS_W'(k);
				end else begin
					lane_noref[k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (is_skip) begin
					pos_q <= pos_base + POS_W'(in_op_length);
				end else begin
					pos_q <= pos_base;
				end
			end else if (cmd.emit && !err_q && has_ref_q) begin
				pos_q <= pos_q + POS_W'(grp_cnt);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q     <= in_op_length[RW-1:0];
			has_ref_q <= is_ref_op;
			err_q     <= dec_err;
		end else if (cmd.emit && !err_q) begin
			rem_q <= rem_q - RW'(grp_cnt);
		end

		if (cmd.emit) begin
			out_pos_q   <= lane_pos;
			out_noref_q <= lane_noref;
			out_cnt_q   <= err_q ? '0 : grp_cnt;
			out_last_q  <= sts.group_last;
			out_err_q   <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_pos        = out_pos_q;
	assign out_noref      = out_noref_q;
	assign out_lane_count = out_cnt_q;
	assign out_run_last   = out_last_q;
	assign out_error      = out_err_q;

endmodule

[design/cigar_reference_position_expander_unit.sv]
// CIGAR reference position expander, top level: controller plus datapath.
// Depends on crpe_pkg, crpe_ctrl, crpe_datapath and the assertion header.
// D, N, H and zero-length runs emit nothing and leave the input ready; an
// emitting run of L bases gives ceil(L/4) output words, one per group of 4 lanes;
// an error word gives one empty error word. Results leave through a registered output.
// Reset clears the running position, the controller state and output valid.
`include "cigar_reference_position_expander_unit_assert.svh"
module cigar_reference_position_expander_unit
	import crpe_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [30:0] start_pos, [58:31] op_length, [63:59] zero
	input  logic [63:0]  s_axis_tdata,
	// [0] first_word, [4:1] op_code
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] pos_lane0, [63:32] pos_lane1, [95:64] pos_lane2, [127:96] pos_lane3,
	// [128] noref_lane0 .. [131] noref_lane3, [134:132] lane_count, [135] zero
	output logic [135:0] m_axis_tdata,
	output logic         m_axis_tlast,
	// [0] op_error
	output logic [0:0]   m_axis_tuser
);

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	logic [POS_W-1:0]     out_pos [OUT_LANES];
	logic [OUT_LANES-1:0] out_noref;
	logic [CNT_W-1:0]     out_lane_count;
	logic                 out_error;

	crpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crpe_datapath #(
		.MAX_READ_LEN (MAX_READ_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_first_word  (s_axis_tuser[0]),
		.in_start_pos   (s_axis_tdata[30:0]),
		.in_op_code     (s_axis_tuser[4:1]),
		.in_op_length   (s_axis_tdata[58:31]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_pos        (out_pos),
		.out_noref      (out_noref),
		.out_lane_count (out_lane_count),
		.out_run_last   (m_axis_tlast),
		.out_error      (out_error)
	);

	assign m_axis_tdata = {1'b0, out_lane_count, out_noref,
		out_pos[3], out_pos[2], out_pos[1], out_pos[0]};
	assign m_axis_tuser = out_error;

	// Error word is a lone, empty, closing word.
	`CRPE_ASSERT(a_err_word_empty, clk, arst_n, m_axis_tvalid && out_error |-> out_lane_count == '0 && m_axis_tlast && out_noref == '0)
	// Regular words carry one to four lanes.
	`CRPE_ASSERT(a_lane_count_range, clk, arst_n, m_axis_tvalid && !out_error |-> out_lane_count != '0 && out_lane_count <= CNT_W'(OUT_LANES))
	// A word that starts a run blocks the input until the run is drained.
	`CRPE_ASSERT(a_busy_after_start, clk, arst_n, cmd.load && sts.run_start |=> !s_axis_tready)
	// Lane 0 without reference position reports position zero.
	`CRPE_NEVER(a_noref_pos_zero, clk, arst_n, m_axis_tvalid && out_noref[0] && out_pos[0] != '0)

endmodule
